[hw/rtl/bounded_ranked_solution_pool_assert.svh]
// Assertion macros for the ranked solution pool checker.
`ifndef BOUNDED_RANKED_SOLUTION_POOL_ASSERT_SVH
`define BOUNDED_RANKED_SOLUTION_POOL_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BRSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define BRSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hw/rtl/brsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsp_pkg
// Status codes, item kinds and shared types of the ranked solution pool.
// ----------------------------------------------------------------------------
package brsp_pkg;
   // Number of ranks the pool storage holds; the internal index widths follow from it.
   localparam int POOL_DEPTH = 16;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_APPENDED = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_DROPPED  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_READ_OK  = 3'd5;
   localparam logic [2:0] ST_BAD_IDX  = 3'd6;
   localparam logic [2:0] ST_CLEARED  = 3'd7;

   typedef logic [2:0] status_type;
   typedef logic [1:0] kind_type;
endpackage

[hw/rtl/brsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module brsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One access a cycle; read data appears the cycle after.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

[hw/rtl/bounded_ranked_solution_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ranked_solution_pool
// Ranked pool of marker-set solutions, ordered by decreasing objective.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake
// req_*    in         start & !busy
// rsp_*    out        rsp_valid, one cycle, no back-pressure
// csr_*    in         csr_valid & csr_ready
//
// A non-last marker joins the pending list. A last marker, unless the list
// overflowed, sorts the pending list (one compare-swap a cycle) and reads the
// worst entry; a solution below it is appended or dropped, else the block
// scans the entries' markers for duplicates and shifts the tail, both one
// marker word at a time. A read returns one result per marker. Reset is
// synchronous; the RAMs need no clearing. The receiver cannot stall the block.
module bounded_ranked_solution_pool #(
   parameter int MAX_MARKERS = 8,
   parameter int MARKER_BITS = 16,
   parameter int OBJ_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic signed [OBJ_BITS-1:0]    req_objective,
   input  logic [MARKER_BITS-1:0]        req_marker,
   input  logic                          req_last_marker,
   input  logic [3:0]                    req_entry_index,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [4:0]                    csr_capacity,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [3:0]                    rsp_position,
   output logic [4:0]                    rsp_pool_size,
   output logic signed [OBJ_BITS-1:0]    rsp_objective_out,
   output logic [MARKER_BITS-1:0]        rsp_marker_out,
   output logic                          rsp_last_out,
   output logic signed [OBJ_BITS-1:0]    rsp_best_objective,
   output logic signed [OBJ_BITS-1:0]    rsp_worst_objective
);
   import brsp_pkg::*;

   localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int MW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
   localparam int CW = $clog2(MAX_MARKERS + 1);
   localparam int NW = $clog2(POOL_DEPTH + 1);
   localparam int AW = $clog2(POOL_DEPTH * MAX_MARKERS);

   // State codes.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SORT  = 4'd1;
   localparam logic [3:0] S_WRD   = 4'd2;  // read worst objective
   localparam logic [3:0] S_WCHK  = 4'd3;
   localparam logic [3:0] S_DRD   = 4'd4;  // duplicate scan, read entry
   localparam logic [3:0] S_DCHK  = 4'd5;
   localparam logic [3:0] S_SHRD  = 4'd6;  // tail shift, read word
   localparam logic [3:0] S_SHWR  = 4'd7;
   localparam logic [3:0] S_PUT   = 4'd8;
   localparam logic [3:0] S_RDOBJ = 4'd9;
   localparam logic [3:0] S_RDMK  = 4'd10;
   localparam logic [3:0] S_RDOUT = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0]                state_ff, state_in;
   logic [NW-1:0]             held_ff, held_in;
   logic [CW-1:0]             pcnt_ff, pcnt_in;
   logic                      povf_ff, povf_in;
   logic [4:0]                cap_ff;
   logic [MARKER_BITS-1:0]    pend_ff [MAX_MARKERS];
   logic [MARKER_BITS-1:0]    pend_in [MAX_MARKERS];
   logic signed [OBJ_BITS-1:0] obj_ff, obj_in;
   logic [PW-1:0]             ent_ff, ent_in;    // entry under work
   logic [MW-1:0]             mi_ff, mi_in;      // marker index
   logic [MW-1:0]             si_ff, si_in;      // sort compare position
   logic [PW-1:0]             pos_ff, pos_in;
   logic                      posf_ff, posf_in;  // position found
   logic                      same_ff, same_in;
   logic [NW-1:0]             newn_ff, newn_in;
   logic [CW-1:0]             rc_ff, rc_in;
   logic [2:0]                st_ff, st_in;
   logic                      lst_ff, lst_in;
   logic [MARKER_BITS-1:0]    mko_ff, mko_in;
   logic signed [OBJ_BITS-1:0] objo_ff, objo_in;

   // Memory ports.
   logic                      om_we, mm_we, cm_we;
   logic [PW-1:0]             om_a, cm_a;
   logic [AW-1:0]             mm_a;
   logic [OBJ_BITS-1:0]       om_wd, om_rd;
   logic [MARKER_BITS-1:0]    mm_wd, mm_rd;
   logic [CW-1:0]             cm_wd, cm_rd;

   brsp_ram #(.WIDTH(OBJ_BITS), .DEPTH(POOL_DEPTH)) u_obj (
      .clock(clock), .we(om_we), .addr(om_a), .wdata(om_wd), .rdata(om_rd));
   brsp_ram #(.WIDTH(CW), .DEPTH(POOL_DEPTH)) u_cnt (
      .clock(clock), .we(cm_we), .addr(cm_a), .wdata(cm_wd), .rdata(cm_rd));
   brsp_ram #(.WIDTH(MARKER_BITS), .DEPTH(POOL_DEPTH * MAX_MARKERS)) u_mk (
      .clock(clock), .we(mm_we), .addr(mm_a), .wdata(mm_wd), .rdata(mm_rd));

   logic [NW-1:0] eff_cap;
   logic [NW-1:0] csr_cap;
   logic          accept;
   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   // Capacity clamped to one through the pool depth.
   always_comb begin
      if (cap_ff == 5'd0) begin
         eff_cap = NW'(1);
      end else if (32'(cap_ff) > POOL_DEPTH) begin
         eff_cap = NW'(POOL_DEPTH);
      end else begin
         eff_cap = NW'(cap_ff);
      end
   end

   // The same clamp applied to a capacity beat being written.
   always_comb begin
      if (csr_capacity == 5'd0) begin
         csr_cap = NW'(1);
      end else if (32'(csr_capacity) > POOL_DEPTH) begin
         csr_cap = NW'(POOL_DEPTH);
      end else begin
         csr_cap = NW'(csr_capacity);
      end
   end

   function automatic logic [AW-1:0] maddr(input logic [PW-1:0] e, input logic [MW-1:0] m);
      maddr = AW'(32'(e) * MAX_MARKERS + 32'(m));
   endfunction

   // Main sequencer.
   always_comb begin
      state_in = state_ff; held_in = held_ff; pcnt_in = pcnt_ff; povf_in = povf_ff;
      pend_in = pend_ff; obj_in = obj_ff;
      ent_in = ent_ff; mi_in = mi_ff; si_in = si_ff; pos_in = pos_ff;
      posf_in = posf_ff; same_in = same_ff; newn_in = newn_ff;
      rc_in = rc_ff; st_in = st_ff; lst_in = lst_ff; mko_in = mko_ff;
      objo_in = objo_ff;
      om_we = 1'b0; mm_we = 1'b0; cm_we = 1'b0;
      om_a = ent_ff; cm_a = ent_ff; mm_a = maddr(ent_ff, mi_ff);
      om_wd = obj_ff; cm_wd = pcnt_ff; mm_wd = pend_ff[mi_ff];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               st_in = ST_CLEARED; lst_in = 1'b1; mko_in = '0; objo_in = '0;
               pos_in = '0;
               case (req_kind)
                  KIND_ADD: begin
                     if (32'(pcnt_ff) < MAX_MARKERS) begin
                        pend_in[pcnt_ff[MW-1:0]] = req_marker;
                        pcnt_in = pcnt_ff + CW'(1);
                     end else begin
                        povf_in = 1'b1;
                     end
                     obj_in = req_objective;
                     si_in = '0; mi_in = '0;
                     if (!req_last_marker) begin
                        state_in = S_DONE;
                     end else if (povf_in) begin
                        st_in = ST_OVERFLOW; state_in = S_EMIT;
                     end else begin
                        state_in = S_SORT;
                     end
                  end
                  KIND_READ: begin
                     if (NW'(req_entry_index) >= held_ff ||
                         32'(req_entry_index) >= POOL_DEPTH) begin
                        st_in = ST_BAD_IDX; state_in = S_EMIT;
                     end else begin
                        ent_in = PW'(req_entry_index); mi_in = '0;
                        state_in = S_RDOBJ;
                     end
                  end
                  KIND_CLEAR: begin
                     held_in = '0; state_in = S_EMIT;
                  end
                  default: state_in = S_DONE;
               endcase
            end else if (csr_valid && csr_ready && held_ff > csr_cap) begin
               // A lowered capacity drops the lowest ranks.
               held_in = csr_cap;
            end
         end
         // Bubble sort: compare-swap at si, sweep repeated count times.
         S_SORT: begin
            if (32'(si_ff) + 1 < 32'(pcnt_ff)) begin
               if (pend_ff[si_ff] > pend_ff[si_ff + MW'(1)]) begin
                  pend_in[si_ff] = pend_ff[si_ff + MW'(1)];
                  pend_in[si_ff + MW'(1)] = pend_ff[si_ff];
               end
               si_in = si_ff + MW'(1);
            end else begin
               si_in = '0;
               if (32'(mi_ff) + 1 < 32'(pcnt_ff)) begin
                  mi_in = mi_ff + MW'(1);
               end else begin
                  mi_in = '0;
                  if (held_ff == '0) begin
                     pos_in = '0; newn_in = NW'(1); ent_in = '0;
                     st_in = ST_INSERTED; state_in = S_PUT;
                  end else begin
                     ent_in = PW'(held_ff - NW'(1)); state_in = S_WRD;
                  end
               end
            end
         end
         S_WRD: begin
            om_a = ent_ff; state_in = S_WCHK;
         end
         S_WCHK: begin
            if (obj_ff < $signed(om_rd)) begin
               if (held_ff < eff_cap) begin
                  pos_in = PW'(held_ff); newn_in = held_ff + NW'(1);
                  st_in = ST_APPENDED; state_in = S_PUT;
               end else begin
                  st_in = ST_DROPPED; state_in = S_EMIT;
               end
            end else begin
               ent_in = '0; mi_in = '0; posf_in = 1'b0;
               pos_in = PW'(held_ff - NW'(1));
               same_in = 1'b1; state_in = S_DRD;
            end
         end
         // Duplicate and position scan: one marker word a step.
         S_DRD: begin
            om_a = ent_ff; cm_a = ent_ff; mm_a = maddr(ent_ff, mi_ff);
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (mi_ff == '0) begin
               if (!posf_ff && !(obj_ff < $signed(om_rd))) begin
                  posf_in = 1'b1; pos_in = ent_ff;
               end
            end
            if (cm_rd != pcnt_ff) begin
               same_in = 1'b0;
            end else if (32'(mi_ff) < 32'(pcnt_ff) && mm_rd != pend_ff[mi_ff]) begin
               same_in = 1'b0;
            end
            if (32'(mi_ff) + 1 < 32'(pcnt_ff) && same_in) begin
               mi_in = mi_ff + MW'(1); state_in = S_DRD;
            end else if (same_in) begin
               st_in = ST_DUP; state_in = S_EMIT;
            end else if (NW'(ent_ff) + NW'(1) < held_ff) begin
               ent_in = ent_ff + PW'(1); mi_in = '0; same_in = 1'b1;
               state_in = S_DRD;
            end else begin
               newn_in = (held_ff < eff_cap) ? held_ff + NW'(1) : eff_cap;
               st_in = ST_INSERTED;
               if (NW'(pos_in) + NW'(1) < newn_in) begin
                  ent_in = PW'(newn_in - NW'(2));
                  mi_in = '0; state_in = S_SHRD;
               end else begin
                  state_in = S_PUT; mi_in = '0;
               end
            end
         end
         // Move entry ent to ent+1, word by word, from the bottom up.
         S_SHRD: begin
            om_a = ent_ff; cm_a = ent_ff; mm_a = maddr(ent_ff, mi_ff);
            state_in = S_SHWR;
         end
         S_SHWR: begin
            mm_we = 1'b1; mm_a = maddr(ent_ff + PW'(1), mi_ff); mm_wd = mm_rd;
            om_we = (mi_ff == '0); om_a = ent_ff + PW'(1); om_wd = om_rd;
            cm_we = (mi_ff == '0); cm_a = ent_ff + PW'(1); cm_wd = cm_rd;
            if (32'(mi_ff) + 1 < MAX_MARKERS) begin
               mi_in = mi_ff + MW'(1); state_in = S_SHRD;
            end else if (ent_ff == pos_ff) begin
               mi_in = '0; state_in = S_PUT;
            end else begin
               mi_in = '0; ent_in = ent_ff - PW'(1); state_in = S_SHRD;
            end
         end
         // Write the new entry at pos.
         S_PUT: begin
            om_we = (mi_ff == '0); om_a = pos_ff; om_wd = obj_ff;
            cm_we = (mi_ff == '0); cm_a = pos_ff; cm_wd = pcnt_ff;
            mm_we = 1'b1; mm_a = maddr(pos_ff, mi_ff);
            mm_wd = (32'(mi_ff) < 32'(pcnt_ff)) ? pend_ff[mi_ff] : '0;
            if (32'(mi_ff) + 1 < MAX_MARKERS) begin
               mi_in = mi_ff + MW'(1);
            end else begin
               held_in = newn_ff; mi_in = '0; ent_in = PW'(newn_ff - NW'(1));
               state_in = S_EMIT;
            end
         end
         S_RDOBJ: begin
            om_a = ent_ff; cm_a = ent_ff; state_in = S_RDMK;
         end
         S_RDMK: begin
            if (mi_ff == '0) begin
               objo_in = om_rd;
               rc_in = (32'(cm_rd) > MAX_MARKERS) ? CW'(MAX_MARKERS) : cm_rd;
            end
            mm_a = maddr(ent_ff, mi_ff);
            if (mi_ff == '0 && cm_rd == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RDOUT;
            end
         end
         S_RDOUT: begin
            st_in = ST_READ_OK; mko_in = mm_rd;
            lst_in = (32'(mi_ff) + 1 == 32'(rc_ff));
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st_ff == ST_READ_OK && !lst_ff) begin
               mi_in = mi_ff + MW'(1); state_in = S_RDMK;
            end else begin
               state_in = S_DONE;
            end
            if (st_ff == ST_OVERFLOW || st_ff == ST_INSERTED || st_ff == ST_APPENDED ||
                st_ff == ST_DROPPED || st_ff == ST_DUP) begin
               pcnt_in = '0; povf_in = 1'b0;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers; the capacity register takes a beat only while idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; held_ff <= '0; pcnt_ff <= '0; povf_ff <= 1'b0;
         cap_ff <= 5'd16;
      end else begin
         state_ff <= state_in; held_ff <= held_in; pcnt_ff <= pcnt_in;
         povf_ff <= povf_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
      end
      pend_ff <= pend_in; obj_ff <= obj_in;
      ent_ff <= ent_in; mi_ff <= mi_in; si_ff <= si_in; pos_ff <= pos_in;
      posf_ff <= posf_in; same_ff <= same_in; newn_ff <= newn_in;
      rc_ff <= rc_in; st_ff <= st_in; lst_ff <= lst_in; mko_ff <= mko_in;
      objo_ff <= objo_in;
   end

   // Pool boundary objectives come from a shadow register file of rank values.
   logic signed [OBJ_BITS-1:0] rank_ff [POOL_DEPTH];
   always_ff @(posedge clock) begin
      if (om_we) begin
         rank_ff[om_a] <= om_wd;
      end
   end

   // Result drive.
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_status = st_ff;
   assign rsp_position = (st_ff == ST_INSERTED || st_ff == ST_APPENDED) ? 4'(pos_ff) : 4'd0;
   assign rsp_pool_size = 5'(held_ff);
   assign rsp_objective_out = (st_ff == ST_READ_OK) ? objo_ff : '0;
   assign rsp_marker_out = (st_ff == ST_READ_OK) ? mko_ff : '0;
   assign rsp_last_out = (st_ff == ST_READ_OK) ? lst_ff : 1'b1;
   assign rsp_best_objective = (held_ff == '0) ? '0 : rank_ff[0];
   assign rsp_worst_objective = (held_ff == '0) ? '0 : rank_ff[PW'(held_ff - NW'(1))];
endmodule

[hw/rtl/brsp_checker.sv]
`timescale 1ns / 1ps
`include "bounded_ranked_solution_pool_assert.svh"
// ----------------------------------------------------------------------------
// brsp_checker
// Port-level checks on the ranked solution pool.
// ----------------------------------------------------------------------------
module brsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_position,
   input logic [4:0] rsp_pool_size
);
   import brsp_pkg::*;

   // A cleared pool reports no entries.
   `BRSP_ASSERT_IMP(a_clear_empty, clock, reset, rsp_valid && rsp_status == ST_CLEARED, rsp_pool_size == 5'd0, "clear left entries")
   // A placed solution lies inside the pool.
   `BRSP_ASSERT_IMP(a_pos_in_pool, clock, reset, rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_APPENDED), 5'(rsp_position) < rsp_pool_size, "position beyond pool")
   // Results only appear while an item is being worked.
   `BRSP_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy, "result while idle")
   // An accepted item keeps the block busy next cycle.
   `BRSP_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
endmodule

bind bounded_ranked_solution_pool brsp_checker u_brsp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_position(rsp_position), .rsp_pool_size(rsp_pool_size));
